[src/dcc_half_bit_decoder_core_defines.svh]
// Assertion macros shared by the half-bit decoder modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef DCC_HALF_BIT_DECODER_CORE_DEFINES_SVH
`define DCC_HALF_BIT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dcc_pkg.sv]
// Shared types, codes and constants of the DCC half-bit decoder.
// Used by every module of the block; depends on nothing.
package dcc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int WORD_BITS_DEF  = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int DATA_W         = 32;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = 2;
    localparam int FIFO_CNT_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BIT_INDEX = 3'd5;

    // Register reset values.
    localparam logic [15:0] ONE_MIN_RST       = 16'd104;
    localparam logic [15:0] ONE_MAX_RST       = 16'd128;
    localparam logic [15:0] ZERO_MIN_RST      = 16'd180;
    localparam logic [15:0] ZERO_MAX_RST      = 16'd20000;
    localparam logic [7:0]  MAX_ERRORS_RST    = 8'd3;
    localparam logic [4:0]  MAX_BIT_INDEX_RST = 5'd31;

    // Event kinds.
    localparam logic [1:0] EV_WORD    = 2'd0;
    localparam logic [1:0] EV_INVALID = 2'd1;
    localparam logic [1:0] EV_LIMIT   = 2'd2;

    // Error classes of an invalid half bit.
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_SHORT = 2'd1;
    localparam logic [1:0] CLS_GAP   = 2'd2;
    localparam logic [1:0] CLS_LONG  = 2'd3;

    typedef enum logic [1:0] {
        PH_STARTUP = 2'd0,
        PH_SEEK    = 2'd1,
        PH_NORMAL  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [15:0] one_min;
        logic [15:0] one_max;
        logic [15:0] zero_min;
        logic [15:0] zero_max;
        logic [7:0]  max_errors;
        logic [4:0]  max_bit_index;
    } cfg_t;

    typedef struct packed {
        logic       is_one;
        logic       is_zero;
        logic [1:0] err_class;
    } class_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] word;
        logic [1:0]        err_class;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

[src/dcc_half_bit_decoder_core.sv]
// Top level of the DCC half-bit decoder: input register, configuration
// registers, phase machine and result queue. Depends on dcc_pkg and all submodules.

// Each input transfer carries the timer count captured at one track-signal edge.
// The period since the previous edge is classified as a one half bit, a zero half
// bit or invalid; matching half bits are paired into bits, and a data word event
// is produced once max_bit_index+1 bits are collected. In the normal phase an
// invalid half bit produces an invalid event with its class, and too many in a
// row add a limit event and send the decoder back to startup. An input item is
// held in an input register, processed once the result queue has room for two
// results, and its zero, one or two results are written into a four-entry result
// queue, whose oldest entry is offered on the output. The block accepts one item
// per cycle as long as the result queue has room for two results; the queue
// drains one output transfer per cycle while out_stall is low, so the sustained
// rate is one item per cycle for items that cause at most one result, and an
// item that causes two results takes two output transfers.
// Configuration writes are taken at any edge with cfg_we high and should only be
// made while the decoder is idle.
module dcc_half_bit_decoder_core #(
    parameter int TIMER_BITS = dcc_pkg::TIMER_BITS_DEF,
    parameter int WORD_BITS  = dcc_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [TIMER_BITS-1:0]           edge_time,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      event_kind,
    output logic [dcc_pkg::DATA_W-1:0]      data_word,
    output logic [1:0]                      error_class,
    output logic                            last
);
    import dcc_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  in_valid_reg;
    logic [TIMER_BITS-1:0] edge_reg;
    logic                  space;
    logic                  fire;
    push_t                 push;
    result_t               head;

    // The held item is processed whenever the queue can absorb its results.
    assign fire     = in_valid_reg && space;
    assign in_stall = in_valid_reg && !space;

    // Configuration register file; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ONE_MIN:       cfg_next.one_min       = cfg_data;
                REG_ONE_MAX:       cfg_next.one_max       = cfg_data;
                REG_ZERO_MIN:      cfg_next.zero_min      = cfg_data;
                REG_ZERO_MAX:      cfg_next.zero_max      = cfg_data;
                REG_MAX_ERRORS:    cfg_next.max_errors    = cfg_data[7:0];
                REG_MAX_BIT_INDEX: cfg_next.max_bit_index = cfg_data[4:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_min       <= ONE_MIN_RST;
            cfg_reg.one_max       <= ONE_MAX_RST;
            cfg_reg.zero_min      <= ZERO_MIN_RST;
            cfg_reg.zero_max      <= ZERO_MAX_RST;
            cfg_reg.max_errors    <= MAX_ERRORS_RST;
            cfg_reg.max_bit_index <= MAX_BIT_INDEX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register: it refills in the same cycle that its item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            edge_reg <= edge_time;
        end
    end

    dcc_fsm #(
        .TIMER_BITS (TIMER_BITS),
        .WORD_BITS  (WORD_BITS)
    ) u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .now_time (edge_reg),
        .cfg      (cfg_reg),
        .push     (push)
    );

    dcc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign event_kind  = head.kind;
    assign data_word   = head.word;
    assign error_class = head.err_class;
    assign last        = head.last;

endmodule

[src/dcc_classify.sv]
// Period measurement and half-bit classification against the timing windows.
// Depends on dcc_pkg.
module dcc_classify #(
    parameter int TIMER_BITS = dcc_pkg::TIMER_BITS_DEF
) (
    input  logic [TIMER_BITS-1:0] now_time,
    input  logic [TIMER_BITS-1:0] prev_time,
    input  dcc_pkg::cfg_t         cfg,
    output dcc_pkg::class_t       cls
);
    import dcc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [TIMER_BITS-1:0] period;
    logic [CMP_W-1:0]      p;
    logic [CMP_W-1:0]      one_min;
    logic [CMP_W-1:0]      one_max;
    logic [CMP_W-1:0]      zero_min;
    logic [CMP_W-1:0]      zero_max;

    // The subtraction wraps at the timer width, matching a free-running counter.
    assign period   = now_time - prev_time;
    assign p        = CMP_W'(period);
    assign one_min  = CMP_W'(cfg.one_min);
    assign one_max  = CMP_W'(cfg.one_max);
    assign zero_min = CMP_W'(cfg.zero_min);
    assign zero_max = CMP_W'(cfg.zero_max);

    always_comb
    begin
        cls.is_one    = (p >= one_min) && (p <= one_max);
        cls.is_zero   = (p >= zero_min) && (p <= zero_max);
        // Later tests take precedence when several match.
        cls.err_class = CLS_NONE;
        if (p < one_min)
        begin
            cls.err_class = CLS_SHORT;
        end
        if ((p > one_max) && (p < zero_min))
        begin
            cls.err_class = CLS_GAP;
        end
        if (p > zero_max)
        begin
            cls.err_class = CLS_LONG;
        end
    end

endmodule

[src/dcc_fsm.sv]
// Phase machine, bit assembly and error counting of the half-bit decoder.
// Depends on dcc_pkg, dcc_classify and the assertion macro header.
`include "dcc_half_bit_decoder_core_defines.svh"

module dcc_fsm #(
    parameter int TIMER_BITS = dcc_pkg::TIMER_BITS_DEF,
    parameter int WORD_BITS  = dcc_pkg::WORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [TIMER_BITS-1:0] now_time,
    input  dcc_pkg::cfg_t         cfg,
    output dcc_pkg::push_t        push
);
    import dcc_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  prev_half_reg, prev_half_next;
    logic                  bit_end_due_reg, bit_end_due_next;
    logic [7:0]            error_run_reg, error_run_next;
    logic [WORD_BITS-1:0]  shift_word_reg, shift_word_next;
    logic [5:0]            bits_held_reg, bits_held_next;
    logic [TIMER_BITS-1:0] prev_time_reg;

    class_t               cls;
    logic                 valid_half;
    logic                 half;
    logic [WORD_BITS-1:0] shifted;
    logic [5:0]           bits_inc;
    logic [7:0]           err_inc;
    logic                 limit_hit;

    dcc_classify #(
        .TIMER_BITS (TIMER_BITS)
    ) u_classify (
        .now_time  (now_time),
        .prev_time (prev_time_reg),
        .cfg       (cfg),
        .cls       (cls)
    );

    assign valid_half = cls.is_one || cls.is_zero;
    assign half       = cls.is_one;
    assign shifted    = {shift_word_reg[WORD_BITS-2:0], half};
    assign bits_inc   = bits_held_reg + 6'd1;
    assign err_inc    = (error_run_reg == 8'hFF) ? 8'hFF : (error_run_reg + 8'd1);
    assign limit_hit  = err_inc > cfg.max_errors;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_STARTUP;
            prev_half_reg   <= 1'b0;
            bit_end_due_reg <= 1'b0;
            error_run_reg   <= 8'd0;
            shift_word_reg  <= '0;
            bits_held_reg   <= 6'd0;
            prev_time_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            prev_half_reg   <= prev_half_next;
            bit_end_due_reg <= bit_end_due_next;
            error_run_reg   <= error_run_next;
            shift_word_reg  <= shift_word_next;
            bits_held_reg   <= bits_held_next;
            prev_time_reg   <= now_time;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        prev_half_next   = prev_half_reg;
        bit_end_due_next = bit_end_due_reg;
        error_run_next   = error_run_reg;
        shift_word_next  = shift_word_reg;
        bits_held_next   = bits_held_reg;
        push             = '0;

        case (phase_reg)
            PH_SEEK:
            begin
                if (valid_half)
                begin
                    if (half != prev_half_reg)
                    begin
                        bit_end_due_next = 1'b1;
                        phase_next       = PH_NORMAL;
                    end
                    prev_half_next = half;
                end
                else
                begin
                    phase_next = PH_STARTUP;
                end
            end
            PH_NORMAL:
            begin
                if (valid_half)
                begin
                    if ((half == prev_half_reg) && bit_end_due_reg)
                    begin
                        // Second matching half closes a bit.
                        shift_word_next  = shifted;
                        bits_held_next   = bits_inc;
                        bit_end_due_next = 1'b0;
                        error_run_next   = 8'd0;
                        if (bits_inc > {1'b0, cfg.max_bit_index})
                        begin
                            push.v0           = fire;
                            push.r0.kind      = EV_WORD;
                            push.r0.word      = DATA_W'(shifted);
                            push.r0.err_class = CLS_NONE;
                            push.r0.last      = 1'b1;
                            shift_word_next   = '0;
                            bits_held_next    = 6'd0;
                        end
                    end
                    else
                    begin
                        bit_end_due_next = 1'b1;
                    end
                    prev_half_next = half;
                end
                else
                begin
                    push.v0           = fire;
                    push.r0.kind      = EV_INVALID;
                    push.r0.word      = '0;
                    push.r0.err_class = cls.err_class;
                    push.r0.last      = !limit_hit;
                    error_run_next    = err_inc;
                    if (limit_hit)
                    begin
                        phase_next        = PH_STARTUP;
                        push.v1           = fire;
                        push.r1.kind      = EV_LIMIT;
                        push.r1.word      = '0;
                        push.r1.err_class = CLS_NONE;
                        push.r1.last      = 1'b1;
                    end
                end
            end
            default:
            begin
                // Startup, and the unused code, which behaves as startup.
                if (valid_half)
                begin
                    bit_end_due_next = 1'b0;
                    error_run_next   = 8'd0;
                    prev_half_next   = half;
                    phase_next       = PH_SEEK;
                end
            end
        endcase
    end

    `DCC_ASSERT_IMP(a_second_needs_first, push.v1, push.v0 && !push.r0.last, "second result without first")
    `DCC_ASSERT_NXT(a_limit_to_startup, push.v1, phase_reg == PH_STARTUP, "limit did not return to startup")
    `DCC_ASSERT_IMP(a_bits_held_range, 1'b1, bits_held_reg[5] == 1'b0, "bit count past word")

endmodule

[src/dcc_result_fifo.sv]
// Four-entry result queue that takes up to two results per cycle and gives one per cycle while not stalled.
// Depends on dcc_pkg and the assertion macro header.
`include "dcc_half_bit_decoder_core_defines.svh"

module dcc_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  dcc_pkg::push_t   push,
    output logic             space,
    output logic             out_valid,
    input  logic             out_stall,
    output dcc_pkg::result_t head
);
    import dcc_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus;
    logic                  pop;

    assign out_valid   = count_reg != '0;
    assign pop         = out_valid && !out_stall;
    // Room for the worst case of two results, counted before this cycle's pop.
    assign space       = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign head        = mem[rd_ptr_reg];
    assign wr_ptr_plus = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.v0) + FIFO_PTR_W'(push.v1);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1)
                      - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_plus] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DCC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH), "queue overfilled")
    `DCC_ASSERT_NXT(a_pop_only, pop && !push.v0 && !push.v1, count_reg == $past(count_reg) - FIFO_CNT_W'(1), "pop miscounted")
    `DCC_ASSERT_IMP(a_push_room, push.v0, space, "push without room")

endmodule
